// ===== src/goertzel_tone_detector_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Goertzel tone detector core.
// Both macros expect signals named clk and rst_n in the scope of use.
// ---------------------------------------------------------------------------
`ifndef GOERTZEL_TONE_DETECTOR_CORE_DEFINES_SVH
`define GOERTZEL_TONE_DETECTOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gtd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtd_pkg
// Types, widths and fixed-point helpers shared by the tone detector modules.
// ---------------------------------------------------------------------------
package gtd_pkg;

  localparam int ACC_W     = 40;              // recurrence state width
  localparam int COEF_FRAC = 14;              // fraction bits of coefficients
  localparam int SAMPLE_W  = 16;
  localparam int COEFF_W   = 17;
  localparam int TERM_W    = 16;
  localparam int POWER_W   = 62;
  localparam int AMP_W     = 31;

  localparam int HALF_W    = ACC_W / 2;       // state is multiplied in two halves
  localparam int MUL_W     = HALF_W + 1;      // signed multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int PACC_W    = ACC_W + COEFF_W + 1;  // full coefficient product
  localparam int PW_W      = 2 * ACC_W + 1;   // sum of two squares
  localparam int ROOT_W    = 64;              // square root datapath

  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = COEFF_W;

  localparam logic [CFG_AW-1:0] CFG_IDX_COEFF = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_IDX_COS   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_IDX_SIN   = 2'd2;

  localparam logic signed [COEFF_W-1:0] COEFF_RST = 17'sd0;
  localparam logic signed [TERM_W-1:0]  COS_RST   = 16'sd16384;
  localparam logic signed [TERM_W-1:0]  SIN_RST   = 16'sd0;

  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic [AMP_W-1:0]   amplitude;
  } out_item_t;

  // Final state of one frame, handed from the recurrence to the magnitude unit.
  typedef struct packed {
    logic signed [ACC_W-1:0] pv;
    logic signed [ACC_W-1:0] pp;
  } frame_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff_two_cos;
    logic signed [TERM_W-1:0]  cos_term;
    logic signed [TERM_W-1:0]  sin_term;
  } cfg_t;

  function automatic logic signed [PROD_W-1:0] mul_s(input logic signed [MUL_W-1:0] a,
                                                     input logic signed [MUL_W-1:0] b);
    mul_s = a * b;
  endfunction

  // Clamp a value one bit wider than the state to the state range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] d;
    d = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    return sat_acc(d);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    return sat_acc(s);
  endfunction

  // Scale a coefficient product down by the fraction bits, rounding to nearest
  // with ties away from zero, and clamp to the state range. For negative
  // products one less is added, which moves ties away from zero as well.
  function automatic logic signed [ACC_W-1:0] round_sat(input logic signed [PACC_W-1:0] p);
    logic [PACC_W-1:0]           r;
    logic [PACC_W-COEF_FRAC-1:0] q;
    logic signed [ACC_W-1:0]     res;
    r = p + (PACC_W'(1) << (COEF_FRAC - 1)) - {{(PACC_W-1){1'b0}}, p[PACC_W-1]};
    q = r[PACC_W-1:COEF_FRAC];
    if (!q[PACC_W-COEF_FRAC-1] && (|q[PACC_W-COEF_FRAC-2:ACC_W-1])) begin
      res = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (q[PACC_W-COEF_FRAC-1] && !(&q[PACC_W-COEF_FRAC-2:ACC_W-1])) begin
      res = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      res = q[ACC_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? -v : v;
  endfunction

endpackage

// ===== src/goertzel_tone_detector_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// goertzel_tone_detector_core
// Single-bin Goertzel detector: recurrence per sample, power and amplitude
// per frame.
//
//   channel  ports                          beat taken when
//   input    push, full, in_data            push high, full low
//   result   empty, pop, out_data           pop high, empty low
//   config   cfg_we, cfg_addr, cfg_wdata    cfg_we high
//
// A sample passes through the recurrence unit in steps: accept, two
// multiplier passes over the halves of the state word, rounding, update.
// In the magnitude unit a frame passes through the products, squares and square root.
// A two-entry frame queue sits between the two, so samples keep flowing while
// earlier frames are worked off; the last sample of a frame waits in the
// recurrence unit while that queue is full, and a result waits in the output
// register until it is popped. Reset is synchronous and takes effect at once.
// ---------------------------------------------------------------------------
module goertzel_tone_detector_core import gtd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_item_t          in_data,
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  cfg_t   cfg_nxt;
  logic   fq_push;
  logic   fq_full;
  frame_t fq_wr_data;
  logic   fq_pop;
  logic   fq_empty;
  frame_t fq_rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_IDX_COEFF: cfg_nxt.coeff_two_cos = cfg_wdata;
        CFG_IDX_COS:   cfg_nxt.cos_term      = cfg_wdata[TERM_W-1:0];
        CFG_IDX_SIN:   cfg_nxt.sin_term      = cfg_wdata[TERM_W-1:0];
        default:       cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coeff_two_cos <= COEFF_RST;
      cfg_r.cos_term      <= COS_RST;
      cfg_r.sin_term      <= SIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gtd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .frame_push (fq_push),
    .frame_full (fq_full),
    .frame      (fq_wr_data)
  );

  gtd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fq_push),
    .wr_data  (fq_wr_data),
    .wr_full  (fq_full),
    .rd_en    (fq_pop),
    .rd_data  (fq_rd_data),
    .rd_empty (fq_empty)
  );

  gtd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_empty (fq_empty),
    .frame_pop   (fq_pop),
    .frame       (fq_rd_data),
    .cfg         (cfg_r),
    .pop         (pop),
    .empty       (empty),
    .out_data    (out_data)
  );

endmodule

// ===== src/gtd_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtd_fifo
// Short queue of finished frames between the recurrence and the magnitude unit.
// ---------------------------------------------------------------------------
module gtd_fifo import gtd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  frame_t wr_data,
  output logic   wr_full,
  input  logic   rd_en,
  output frame_t rd_data,
  output logic   rd_empty
);

  frame_t             mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0]   wr_ptr_r;
  logic [FQ_AW-1:0]   wr_ptr_nxt;
  logic [FQ_AW-1:0]   rd_ptr_r;
  logic [FQ_AW-1:0]   rd_ptr_nxt;
  logic [FQ_CW-1:0]   count_r;
  logic [FQ_CW-1:0]   count_nxt;
  logic               do_wr;
  logic               do_rd;

  assign wr_full  = (count_r == FQ_CW'(FQ_DEPTH));
  assign rd_empty = (count_r == '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !wr_full;
  assign do_rd    = rd_en && !rd_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/gtd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtd_front
// Accepts samples and runs the Goertzel recurrence; queues the state at frame end.
// ---------------------------------------------------------------------------
module gtd_front import gtd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     frame_push,
  input  logic     frame_full,
  output frame_t   frame
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MHI  = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_RND  = 3'd3;
  localparam logic [2:0] F_UPD  = 3'd4;

  logic [2:0]                 state_r;
  logic [2:0]                 state_nxt;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] x_nxt;
  logic                       last_r;
  logic                       last_nxt;
  logic signed [ACC_W-1:0]    pv_r;
  logic signed [ACC_W-1:0]    pv_nxt;
  logic signed [ACC_W-1:0]    pp_r;
  logic signed [ACC_W-1:0]    pp_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PACC_W-1:0]   acc_r;
  logic signed [PACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]    u_r;
  logic signed [ACC_W-1:0]    u_nxt;

  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [PACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]    u0;

  // The state word enters the multiplier as an unsigned low half and a signed
  // high half; the two partial products are summed with a 20-bit offset.
  assign mul_a    = (state_r == F_IDLE) ? {1'b0, pv_r[HALF_W-1:0]}
                                        : {pv_r[ACC_W-1], pv_r[ACC_W-1:HALF_W]};
  assign mul_b    = {{(MUL_W-COEFF_W){cfg.coeff_two_cos[COEFF_W-1]}}, cfg.coeff_two_cos};
  assign prod_ext = {{(PACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign u0       = sat_add(sat_sub(u_r, pp_r), {{(ACC_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r});
  assign full     = (state_r != F_IDLE);
  assign frame.pv = u0;
  assign frame.pp = pv_r;

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    last_nxt   = last_r;
    pv_nxt     = pv_r;
    pp_nxt     = pp_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    u_nxt      = u_r;
    frame_push = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (push) begin
          x_nxt     = in_data.sample;
          last_nxt  = in_data.last_sample;
          prod_nxt  = mul_s(mul_a, mul_b);
          state_nxt = F_MHI;
        end
      end
      F_MHI: begin
        acc_nxt   = prod_ext;
        prod_nxt  = mul_s(mul_a, mul_b);
        state_nxt = F_SUM;
      end
      F_SUM: begin
        acc_nxt   = acc_r + (prod_ext <<< HALF_W);
        state_nxt = F_RND;
      end
      F_RND: begin
        u_nxt     = round_sat(acc_r);
        state_nxt = F_UPD;
      end
      F_UPD: begin
        if (!last_r) begin
          pp_nxt    = pv_r;
          pv_nxt    = u0;
          state_nxt = F_IDLE;
        end else if (!frame_full) begin
          // Frame end: hand the final state to the back end and start afresh.
          frame_push = 1'b1;
          pp_nxt     = '0;
          pv_nxt     = '0;
          state_nxt  = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      pv_r    <= '0;
      pp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= pv_nxt;
      pp_r    <= pp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    last_r <= last_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    u_r    <= u_nxt;
  end

endmodule

// ===== src/gtd_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtd_back
// Turns a frame's final state into power and amplitude with one shared
// multiplier and a bit-pair square root, and holds the result for the reader.
// ---------------------------------------------------------------------------
module gtd_back import gtd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      frame_empty,
  output logic      frame_pop,
  input  frame_t    frame,
  input  cfg_t      cfg,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  localparam logic [4:0] B_IDLE  = 5'd0;
  localparam logic [4:0] B_C0    = 5'd1;
  localparam logic [4:0] B_C1    = 5'd2;
  localparam logic [4:0] B_C2    = 5'd3;
  localparam logic [4:0] B_C3    = 5'd4;
  localparam logic [4:0] B_S1    = 5'd5;
  localparam logic [4:0] B_S2    = 5'd6;
  localparam logic [4:0] B_S3    = 5'd7;
  localparam logic [4:0] B_Q0    = 5'd8;
  localparam logic [4:0] B_Q1    = 5'd9;
  localparam logic [4:0] B_Q2    = 5'd10;
  localparam logic [4:0] B_Q3    = 5'd11;
  localparam logic [4:0] B_Q4    = 5'd12;
  localparam logic [4:0] B_Q5    = 5'd13;
  localparam logic [4:0] B_Q6    = 5'd14;
  localparam logic [4:0] B_CLAMP = 5'd15;
  localparam logic [4:0] B_ROOT  = 5'd16;
  localparam logic [4:0] B_DONE  = 5'd17;

  logic [4:0]               state_r;
  logic [4:0]               state_nxt;
  logic signed [ACC_W-1:0]  pv_r;
  logic signed [ACC_W-1:0]  pv_nxt;
  logic signed [ACC_W-1:0]  pp_r;
  logic signed [ACC_W-1:0]  pp_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PACC_W-1:0] acc_r;
  logic signed [PACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0]  rc_r;
  logic signed [ACC_W-1:0]  rc_nxt;
  logic signed [ACC_W-1:0]  re_r;
  logic signed [ACC_W-1:0]  re_nxt;
  logic signed [ACC_W-1:0]  im_r;
  logic signed [ACC_W-1:0]  im_nxt;
  logic [ACC_W-1:0]         mre_r;
  logic [ACC_W-1:0]         mre_nxt;
  logic [ACC_W-1:0]         mim_r;
  logic [ACC_W-1:0]         mim_nxt;
  logic [PW_W-1:0]          pw_r;
  logic [PW_W-1:0]          pw_nxt;
  logic [POWER_W-1:0]       power_r;
  logic [POWER_W-1:0]       power_nxt;
  logic [ROOT_W-1:0]        v_r;
  logic [ROOT_W-1:0]        v_nxt;
  logic [ROOT_W-1:0]        res_r;
  logic [ROOT_W-1:0]        res_nxt;
  logic [ROOT_W-1:0]        bit_r;
  logic [ROOT_W-1:0]        bit_nxt;
  out_item_t                out_r;
  out_item_t                out_nxt;
  logic                     out_vld_r;
  logic                     out_vld_nxt;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]  cos_ext;
  logic signed [MUL_W-1:0]  sin_ext;
  logic signed [MUL_W-1:0]  pp_lo;
  logic signed [MUL_W-1:0]  pp_hi;
  logic signed [MUL_W-1:0]  re_lo;
  logic signed [MUL_W-1:0]  re_hi;
  logic signed [MUL_W-1:0]  im_lo;
  logic signed [MUL_W-1:0]  im_hi;
  logic signed [PACC_W-1:0] prod_ext;
  logic [PW_W-1:0]          prod_pw;
  logic [ROOT_W-1:0]        trial;

  assign cos_ext  = {{(MUL_W-TERM_W){cfg.cos_term[TERM_W-1]}}, cfg.cos_term};
  assign sin_ext  = {{(MUL_W-TERM_W){cfg.sin_term[TERM_W-1]}}, cfg.sin_term};
  assign pp_lo    = {1'b0, pp_r[HALF_W-1:0]};
  assign pp_hi    = {pp_r[ACC_W-1], pp_r[ACC_W-1:HALF_W]};
  assign re_lo    = {1'b0, mre_r[HALF_W-1:0]};
  assign re_hi    = {1'b0, mre_r[ACC_W-1:HALF_W]};
  assign im_lo    = {1'b0, mim_r[HALF_W-1:0]};
  assign im_hi    = {1'b0, mim_r[ACC_W-1:HALF_W]};
  assign prod_ext = {{(PACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  // Square terms are never negative, so the product is zero-extended.
  assign prod_pw  = {{(PW_W-PROD_W){1'b0}}, prod_r};
  assign trial    = res_r + bit_r;

  assign empty    = !out_vld_r;
  assign out_data = out_r;

  always_comb begin
    case (state_r)
      B_C0:    begin mul_a = pp_lo; mul_b = cos_ext; end
      B_C1:    begin mul_a = pp_hi; mul_b = cos_ext; end
      B_C3:    begin mul_a = pp_lo; mul_b = sin_ext; end
      B_S1:    begin mul_a = pp_hi; mul_b = sin_ext; end
      B_Q0:    begin mul_a = re_lo; mul_b = re_lo;   end
      B_Q1:    begin mul_a = re_lo; mul_b = re_hi;   end
      B_Q2:    begin mul_a = re_hi; mul_b = re_hi;   end
      B_Q3:    begin mul_a = im_lo; mul_b = im_lo;   end
      B_Q4:    begin mul_a = im_lo; mul_b = im_hi;   end
      B_Q5:    begin mul_a = im_hi; mul_b = im_hi;   end
      default: begin mul_a = pp_lo; mul_b = cos_ext; end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    pv_nxt      = pv_r;
    pp_nxt      = pp_r;
    prod_nxt    = mul_s(mul_a, mul_b);
    acc_nxt     = acc_r;
    rc_nxt      = rc_r;
    re_nxt      = re_r;
    im_nxt      = im_r;
    mre_nxt     = mre_r;
    mim_nxt     = mim_r;
    pw_nxt      = pw_r;
    power_nxt   = power_r;
    v_nxt       = v_r;
    res_nxt     = res_r;
    bit_nxt     = bit_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !pop;
    frame_pop   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!frame_empty) begin
          frame_pop = 1'b1;
          pv_nxt    = frame.pv;
          pp_nxt    = frame.pp;
          state_nxt = B_C0;
        end
      end
      B_C0: state_nxt = B_C1;
      B_C1: begin
        acc_nxt   = prod_ext;
        state_nxt = B_C2;
      end
      B_C2: begin
        acc_nxt   = acc_r + (prod_ext <<< HALF_W);
        state_nxt = B_C3;
      end
      B_C3: begin
        rc_nxt    = round_sat(acc_r);
        state_nxt = B_S1;
      end
      B_S1: begin
        re_nxt    = sat_sub(pv_r, rc_r);
        acc_nxt   = prod_ext;
        state_nxt = B_S2;
      end
      B_S2: begin
        mre_nxt   = abs_acc(re_r);
        acc_nxt   = acc_r + (prod_ext <<< HALF_W);
        state_nxt = B_S3;
      end
      B_S3: begin
        im_nxt    = round_sat(acc_r);
        state_nxt = B_Q0;
      end
      B_Q0: begin
        mim_nxt   = abs_acc(im_r);
        state_nxt = B_Q1;
      end
      // Each square is lo*lo + 2*lo*hi << 20 + hi*hi << 40, summed exactly.
      B_Q1: begin
        pw_nxt    = prod_pw;
        state_nxt = B_Q2;
      end
      B_Q2: begin
        pw_nxt    = pw_r + (prod_pw << (HALF_W + 1));
        state_nxt = B_Q3;
      end
      B_Q3: begin
        pw_nxt    = pw_r + (prod_pw << (2 * HALF_W));
        state_nxt = B_Q4;
      end
      B_Q4: begin
        pw_nxt    = pw_r + prod_pw;
        state_nxt = B_Q5;
      end
      B_Q5: begin
        pw_nxt    = pw_r + (prod_pw << (HALF_W + 1));
        state_nxt = B_Q6;
      end
      B_Q6: begin
        pw_nxt    = pw_r + (prod_pw << (2 * HALF_W));
        state_nxt = B_CLAMP;
      end
      B_CLAMP: begin
        power_nxt = (|pw_r[PW_W-1:POWER_W]) ? {POWER_W{1'b1}} : pw_r[POWER_W-1:0];
        v_nxt     = {{(ROOT_W-POWER_W){1'b0}}, power_nxt};
        res_nxt   = '0;
        bit_nxt   = ROOT_W'(1) << POWER_W;
        state_nxt = B_ROOT;
      end
      B_ROOT: begin
        // One result bit per cycle, testing bit pairs from the top down.
        if (v_r >= trial) begin
          v_nxt   = v_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_vld_r || pop) begin
          out_nxt.power     = power_r;
          out_nxt.amplitude = res_r[AMP_W-1:0];
          out_vld_nxt       = 1'b1;
          state_nxt         = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pv_r    <= pv_nxt;
    pp_r    <= pp_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    rc_r    <= rc_nxt;
    re_r    <= re_nxt;
    im_r    <= im_nxt;
    mre_r   <= mre_nxt;
    mim_r   <= mim_nxt;
    pw_r    <= pw_nxt;
    power_r <= power_nxt;
    v_r     <= v_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ===== src/gtd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtd_checker
// Port-level checks on the tone detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "goertzel_tone_detector_core_defines.svh"

module gtd_checker import gtd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      push,
  input logic      full,
  input logic      pop,
  input logic      empty,
  input out_item_t out_data
);

  logic [63:0] amp_sq;
  logic [63:0] amp_next_sq;
  logic [63:0] power_ext;
  logic        root_ok;

  assign amp_sq      = 64'(out_data.amplitude) * 64'(out_data.amplitude);
  assign amp_next_sq = (64'(out_data.amplitude) + 64'd1) * (64'(out_data.amplitude) + 64'd1);
  assign power_ext   = 64'(out_data.power);
  assign root_ok     = (amp_sq <= power_ext) && (amp_next_sq > power_ext);

  // Coming out of reset nothing is pending and the input side is open.
  `GTD_ASSERT_SAME(a_reset_idle, !$past(rst_n), empty && !full, "not idle after reset")

  // The amplitude shown is the floor of the square root of the power shown.
  `GTD_ASSERT_SAME(a_root_match, !empty, root_ok, "amplitude is not the root of power")

  // A sample keeps the recurrence unit busy for the following cycle.
  `GTD_ASSERT_NEXT(a_busy_after_accept, push && !full, full, "input open after a sample")

  // A result that is not taken stays in place.
  `GTD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_data), "result moved")

endmodule

bind goertzel_tone_detector_core gtd_checker u_gtd_checker (.*);
